// ===== rtl/lvsm_pkg.sv =====
// Shared types and constants for the low-voltage shutdown monitor.
// No dependencies; used by lvsm_step and low_voltage_shutdown_monitor_top.
`timescale 1ns / 1ps
`default_nettype none

package lvsm_pkg;

   // Internal mode, one-hot
   typedef enum logic [4:0] {
      MODE_NORMAL      = 5'b00001,
      MODE_CHECK       = 5'b00010,
      MODE_CONFIRM     = 5'b00100,
      MODE_SHUTDOWN    = 5'b01000,
      MODE_WORKING_LOW = 5'b10000
   } mode_type;

   // Mode codes as reported on the result beat
   localparam logic [2:0] MODE_CODE_NORMAL      = 3'd0;
   localparam logic [2:0] MODE_CODE_CHECK       = 3'd1;
   localparam logic [2:0] MODE_CODE_CONFIRM     = 3'd2;
   localparam logic [2:0] MODE_CODE_SHUTDOWN    = 3'd3;
   localparam logic [2:0] MODE_CODE_WORKING_LOW = 3'd4;

   localparam logic [7:0] COUNT_MAX = 8'd255;

   // Register indexes on the csr port
   localparam logic [7:0] CSR_LOW_THRESHOLD     = 8'd0;
   localparam logic [7:0] CSR_WORKING_THRESHOLD = 8'd1;
   localparam logic [7:0] CSR_CHECK_INTERVAL    = 8'd2;
   localparam logic [7:0] CSR_CONFIRM_LIMIT     = 8'd3;

   // Reset values of the registers
   localparam logic [15:0] LOW_THRESHOLD_RESET     = 16'd3150;
   localparam logic [15:0] WORKING_THRESHOLD_RESET = 16'd3150;
   localparam logic [31:0] CHECK_INTERVAL_RESET    = 32'd500;
   localparam logic [7:0]  CONFIRM_LIMIT_RESET     = 8'd5;

   typedef struct packed {
      logic [15:0] low_threshold_mv;
      logic [15:0] working_threshold_mv;
      logic [31:0] check_interval_ticks;
      logic [7:0]  confirm_limit;
   } cfg_type;

   typedef struct packed {
      mode_type    mode;
      logic [31:0] last_check_tick;
      logic [7:0]  low_sample_count;
   } state_type;

   // Map one-hot mode to its reported code
   function automatic logic [2:0] mode_code(input mode_type m);
      logic [2:0] code;
      code = MODE_CODE_NORMAL;
      unique case (m)
         MODE_NORMAL:      code = MODE_CODE_NORMAL;
         MODE_CHECK:       code = MODE_CODE_CHECK;
         MODE_CONFIRM:     code = MODE_CODE_CONFIRM;
         MODE_SHUTDOWN:    code = MODE_CODE_SHUTDOWN;
         MODE_WORKING_LOW: code = MODE_CODE_WORKING_LOW;
         default:          code = MODE_CODE_NORMAL;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/low_voltage_shutdown_monitor_top.sv =====
// Low-voltage shutdown monitor top level: input register, step logic, result register.
// Depends on lvsm_pkg and lvsm_step.
`timescale 1ns / 1ps
`default_nettype none

// Each req beat is one monitor pass (voltage, tick, charging flag) and yields exactly
// one rsp beat with the mode after the pass, the charger shutdown request and the low
// sample count. A beat is registered on entry, evaluated from the input register and
// loaded into the result register, which drives rsp_tvalid. One beat is taken every
// cycle while the result side is not stalled; the mode/tick/count state register
// updates in the same cycle the result register loads. Both sides stall cleanly.
// Registers are written through the csr port (index 0..3, others ignored), which is
// always ready; write them only while no pass is in flight.

module low_voltage_shutdown_monitor_top (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // [15:0] voltage_mv, [47:16] tick_now, [48] charging
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [2:0] mode, [3] shutdown_request, [11:4] low_samples
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [31:0] csr_data
);

   lvsm_pkg::cfg_type   cfg_ff;
   lvsm_pkg::state_type state_ff;
   lvsm_pkg::state_type state_in;

   logic        s1_valid_ff;
   logic [15:0] voltage_ff;
   logic [31:0] tick_ff;
   logic        charging_ff;

   logic        rsp_valid_ff;
   logic [2:0]  rsp_mode_ff;
   logic        rsp_request_ff;
   logic [7:0]  rsp_count_ff;

   logic        request_in;
   logic        advance;

   // Register file writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_threshold_mv     <= lvsm_pkg::LOW_THRESHOLD_RESET;
         cfg_ff.working_threshold_mv <= lvsm_pkg::WORKING_THRESHOLD_RESET;
         cfg_ff.check_interval_ticks <= lvsm_pkg::CHECK_INTERVAL_RESET;
         cfg_ff.confirm_limit        <= lvsm_pkg::CONFIRM_LIMIT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            lvsm_pkg::CSR_LOW_THRESHOLD:     cfg_ff.low_threshold_mv     <= csr_data[15:0];
            lvsm_pkg::CSR_WORKING_THRESHOLD: cfg_ff.working_threshold_mv <= csr_data[15:0];
            lvsm_pkg::CSR_CHECK_INTERVAL:    cfg_ff.check_interval_ticks <= csr_data;
            lvsm_pkg::CSR_CONFIRM_LIMIT:     cfg_ff.confirm_limit        <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // Handshake: move the input stage on when the result slot is free or draining
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         voltage_ff  <= req_tdata[15:0];
         tick_ff     <= req_tdata[47:16];
         charging_ff <= req_tdata[48];
      end
   end

   lvsm_step u_step (
      .cfg              (cfg_ff),
      .state_cur        (state_ff),
      .voltage_mv       (voltage_ff),
      .tick_now         (tick_ff),
      .charging         (charging_ff),
      .state_nxt        (state_in),
      .shutdown_request (request_in)
   );

   // Monitor state: update once per evaluated beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode             <= lvsm_pkg::MODE_NORMAL;
         state_ff.last_check_tick  <= 32'd0;
         state_ff.low_sample_count <= 8'd0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_mode_ff    <= lvsm_pkg::mode_code(state_in.mode);
         rsp_request_ff <= request_in;
         rsp_count_ff   <= state_in.low_sample_count;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_count_ff, rsp_request_ff, rsp_mode_ff};

   // A shutdown request is only ever reported together with shutdown mode
   a_request_mode: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[3]) |-> (rsp_tdata[2:0] == lvsm_pkg::MODE_CODE_SHUTDOWN))
      else $error("shutdown request without shutdown mode");

   // Confirm always moves to shutdown on the next evaluated beat
   a_confirm_next: assert property (@(posedge clock) disable iff (reset)
      (advance && state_ff.mode == lvsm_pkg::MODE_CONFIRM)
      |=> (state_ff.mode == lvsm_pkg::MODE_SHUTDOWN))
      else $error("confirm did not lead to shutdown");

   // State holds while no beat is evaluated
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("monitor state changed without a beat");

   // A full pipeline with a stalled output refuses new beats
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("input accepted while pipeline is full and stalled");

endmodule

`default_nettype wire

// ===== rtl/lvsm_step.sv =====
// One monitor pass: next mode, check tick and low count from the current state.
// Depends on lvsm_pkg (cfg_type, state_type, mode_type).
`timescale 1ns / 1ps
`default_nettype none

module lvsm_step (
   input  lvsm_pkg::cfg_type   cfg,
   input  lvsm_pkg::state_type state_cur,
   input  logic [15:0]         voltage_mv,
   input  logic [31:0]         tick_now,
   input  logic                charging,
   output lvsm_pkg::state_type state_nxt,
   output logic                shutdown_request
);

   logic        is_low;
   logic        is_working_low;
   logic        elapsed;
   logic [31:0] tick_diff;
   logic [7:0]  count_inc;

   // Classify the sample; zero voltage is never low
   assign is_low         = (voltage_mv != 16'd0) && (voltage_mv <= cfg.low_threshold_mv);
   assign is_working_low = (voltage_mv != 16'd0) && (voltage_mv <= cfg.working_threshold_mv);

   // Wrapping interval check
   assign tick_diff = tick_now - state_cur.last_check_tick;
   assign elapsed   = tick_diff >= cfg.check_interval_ticks;

   // Saturating increment of the low count
   assign count_inc = (state_cur.low_sample_count < lvsm_pkg::COUNT_MAX) ?
                      state_cur.low_sample_count + 8'd1 : state_cur.low_sample_count;

   // Mode transitions
   always_comb begin
      state_nxt        = state_cur;
      shutdown_request = 1'b0;
      unique case (state_cur.mode)
         lvsm_pkg::MODE_NORMAL: begin
            if (is_low) begin
               state_nxt.mode             = lvsm_pkg::MODE_CHECK;
               state_nxt.low_sample_count = 8'd0;
               state_nxt.last_check_tick  = tick_now;
            end else if (is_working_low) begin
               state_nxt.mode = lvsm_pkg::MODE_WORKING_LOW;
            end
         end
         lvsm_pkg::MODE_WORKING_LOW: begin
            if (elapsed) begin
               state_nxt.last_check_tick = tick_now;
               if (is_low) begin
                  state_nxt.mode             = lvsm_pkg::MODE_CHECK;
                  state_nxt.low_sample_count = 8'd0;
               end else if (voltage_mv > cfg.working_threshold_mv) begin
                  state_nxt.mode = lvsm_pkg::MODE_NORMAL;
               end
            end
         end
         lvsm_pkg::MODE_CHECK: begin
            if (elapsed) begin
               state_nxt.last_check_tick = tick_now;
               if (is_low) begin
                  state_nxt.low_sample_count = count_inc;
                  if (count_inc >= cfg.confirm_limit) begin
                     state_nxt.mode = lvsm_pkg::MODE_CONFIRM;
                  end
               end else begin
                  state_nxt.mode = lvsm_pkg::MODE_NORMAL;
               end
            end
         end
         lvsm_pkg::MODE_CONFIRM: begin
            shutdown_request = !charging;
            state_nxt.mode   = lvsm_pkg::MODE_SHUTDOWN;
         end
         default: begin
            // Shutdown and any stray code return to normal
            state_nxt.mode = lvsm_pkg::MODE_NORMAL;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== tb/low_voltage_shutdown_monitor_top_test.sv =====
// Self-checking testbench for low_voltage_shutdown_monitor_top: directed passes, then random ones.
// Depends on lvsm_pkg for register indexes, mode codes and reset values; reads no files.
`timescale 1ns / 1ps

module low_voltage_shutdown_monitor_top_test;

   localparam int unsigned WATCHDOG_LIMIT = 4000;
   localparam int unsigned MAX_REPORTS    = 10;
   localparam logic [7:0]  CSR_UNMAPPED_FIRST = lvsm_pkg::CSR_CONFIRM_LIMIT + 8'd1;

   typedef struct packed {
      logic [2:0] mode;
      logic       shutdown_request;
      logic [7:0] low_samples;
   } status_beat_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata   = '0;   // [15:0] voltage_mv, [47:16] tick_now, [48] charging
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [15:0] rsp_tdata;          // [2:0] mode, [3] shutdown_request, [11:4] low_samples
   logic        csr_valid   = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index   = '0;
   logic [31:0] csr_data    = '0;

   // Shadow copy of the registers and the monitor state
   logic [15:0] cfg_low_mv;
   logic [15:0] cfg_work_mv;
   logic [31:0] cfg_interval;
   logic [7:0]  cfg_confirm;
   logic [2:0]  mon_mode;
   logic [31:0] mon_last_tick;
   logic [7:0]  mon_low_count;

   status_beat_type expected_status[$];

   int unsigned burst_left;
   int unsigned passes_sent;
   int unsigned results_checked;
   int unsigned mismatch_count;
   int unsigned shutdowns_predicted;
   int unsigned settings_loaded;
   int unsigned stall_cycles;
   logic [7:0]  peak_low_count;

   low_voltage_shutdown_monitor_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Advance the shadow monitor by one pass and queue the status it should report
   task automatic advance_monitor(input logic [15:0] volts, input logic [31:0] now,
                                  input logic charging);
      status_beat_type s;
      logic            is_low;
      logic            elapsed;
      is_low  = (volts != 16'd0) && (volts <= cfg_low_mv);
      elapsed = ((now - mon_last_tick) >= cfg_interval);
      s.shutdown_request = 1'b0;
      case (mon_mode)
         lvsm_pkg::MODE_CODE_NORMAL: begin
            if (is_low) begin
               mon_mode      = lvsm_pkg::MODE_CODE_CHECK;
               mon_low_count = 8'd0;
               mon_last_tick = now;
            end else if (volts != 16'd0 && volts <= cfg_work_mv) begin
               mon_mode = lvsm_pkg::MODE_CODE_WORKING_LOW;
            end
         end
         lvsm_pkg::MODE_CODE_WORKING_LOW: begin
            if (elapsed) begin
               mon_last_tick = now;
               if (is_low) begin
                  mon_mode      = lvsm_pkg::MODE_CODE_CHECK;
                  mon_low_count = 8'd0;
               end else if (volts > cfg_work_mv) begin
                  mon_mode = lvsm_pkg::MODE_CODE_NORMAL;
               end
            end
         end
         lvsm_pkg::MODE_CODE_CHECK: begin
            if (elapsed) begin
               mon_last_tick = now;
               if (is_low) begin
                  if (mon_low_count != lvsm_pkg::COUNT_MAX)
                     mon_low_count = mon_low_count + 8'd1;
                  if (mon_low_count >= cfg_confirm) mon_mode = lvsm_pkg::MODE_CODE_CONFIRM;
               end else begin
                  mon_mode = lvsm_pkg::MODE_CODE_NORMAL;
               end
            end
         end
         lvsm_pkg::MODE_CODE_CONFIRM: begin
            s.shutdown_request = !charging;
            mon_mode = lvsm_pkg::MODE_CODE_SHUTDOWN;
         end
         default: begin
            mon_mode = lvsm_pkg::MODE_CODE_NORMAL;
         end
      endcase
      s.mode        = mon_mode;
      s.low_samples = mon_low_count;
      if (s.shutdown_request) shutdowns_predicted++;
      if (mon_low_count > peak_low_count) peak_low_count = mon_low_count;
      expected_status.push_back(s);
   endtask

   // Send one pass; open a new burst after a random gap when the old one is spent
   task automatic send_pass(input logic [15:0] volts, input logic [31:0] now,
                            input logic charging);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(4, 0) == 0) ? $urandom_range(40, 20)
                                                  : $urandom_range(10, 1);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, charging, now, volts};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      passes_sent++;
      advance_monitor(volts, now, charging);
   endtask

   // Hold off until every queued status has come back and the pipeline is empty
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [7:0] index, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         lvsm_pkg::CSR_LOW_THRESHOLD:     cfg_low_mv   = data[15:0];
         lvsm_pkg::CSR_WORKING_THRESHOLD: cfg_work_mv  = data[15:0];
         lvsm_pkg::CSR_CHECK_INTERVAL:    cfg_interval = data;
         lvsm_pkg::CSR_CONFIRM_LIMIT:     cfg_confirm  = data[7:0];
         default: ;
      endcase
   endtask

   // Write all four registers plus one unmapped index, which must be ignored
   task automatic load_settings(input logic [31:0] low_mv, input logic [31:0] work_mv,
                                input logic [31:0] interval, input logic [31:0] confirm);
      wait_drained();
      write_csr(lvsm_pkg::CSR_LOW_THRESHOLD, low_mv);
      write_csr(lvsm_pkg::CSR_WORKING_THRESHOLD, work_mv);
      write_csr(lvsm_pkg::CSR_CHECK_INTERVAL, interval);
      write_csr(lvsm_pkg::CSR_CONFIRM_LIMIT, confirm);
      write_csr(8'($urandom_range(255, CSR_UNMAPPED_FIRST)), $urandom);
      csr_valid <= 1'b0;
      settings_loaded++;
   endtask

   // Voltages cluster on the thresholds, with extremes and full-range noise
   function automatic logic [15:0] pick_voltage(input int unsigned zero_pct);
      if ($urandom_range(99, 0) < zero_pct) return 16'd0;
      case ($urandom_range(7, 0))
         0: return cfg_low_mv;
         1: return (cfg_low_mv == 16'hFFFF) ? 16'hFFFF : cfg_low_mv + 16'd1;
         2: return cfg_work_mv;
         3: return (cfg_work_mv == 16'hFFFF) ? 16'hFFFF : cfg_work_mv + 16'd1;
         4: return 16'($urandom_range(cfg_low_mv, 1));
         5: return 16'hFFFF;
         6: return 16'($urandom_range(16'hFFFF, cfg_work_mv));
         default: return 16'($urandom);
      endcase
   endfunction

   // Ticks land on, just short of and just past the next re-check point, within the interval or anywhere
   function automatic logic [31:0] pick_tick();
      case ($urandom_range(9, 0))
         0, 1, 2: return mon_last_tick + cfg_interval;
         3:       return mon_last_tick + cfg_interval - 32'd1;
         4:       return mon_last_tick + cfg_interval + 32'($urandom_range(3, 1));
         5, 6:    return mon_last_tick + 32'($urandom_range(cfg_interval, 0));
         default: return $urandom;
      endcase
   endfunction

   task automatic run_random(input int unsigned count, input int unsigned zero_pct);
      for (int unsigned i = 0; i < count; i++)
         send_pass(pick_voltage(zero_pct), pick_tick(), 1'($urandom_range(1, 0)));
   endtask

   // Reset settings: invalid zero, full scale, then a full confirm and shutdown cycle
   task automatic test_reset_settings();
      send_pass(16'd0, 32'd0, 1'b0);
      send_pass(16'hFFFF, 32'd20, 1'b0);
      send_pass(lvsm_pkg::LOW_THRESHOLD_RESET, 32'd100, 1'b0);
      send_pass(16'd1, 32'd599, 1'b0);
      for (int unsigned i = 1; i <= 5; i++)
         send_pass(16'd1, 32'd100 + 32'(i) * lvsm_pkg::CHECK_INTERVAL_RESET, 1'b0);
      send_pass(16'd4000, 32'd2601, 1'b0);
      send_pass(16'd4000, 32'd2602, 1'b1);
   endtask

   // Working-low band entry, hold and exit, zero sample, charger suppression
   task automatic test_working_band();
      load_settings(32'd3000, 32'd3500, 32'd20, 32'd1);
      send_pass(16'd3400, 32'd3000, 1'b0);
      send_pass(16'd3100, 32'd3005, 1'b0);
      send_pass(16'd2000, 32'd3010, 1'b0);
      send_pass(16'd3600, 32'd3025, 1'b0);
      send_pass(16'd3400, 32'd3030, 1'b0);
      send_pass(16'd0, 32'd3050, 1'b0);
      send_pass(16'd2500, 32'd3070, 1'b0);
      send_pass(16'd2500, 32'd3090, 1'b0);
      send_pass(16'd2500, 32'd3091, 1'b1);
      send_pass(16'd2500, 32'd3092, 1'b0);
   endtask

   // Truncated register data, maximum interval, zero confirm limit, tick wrap
   task automatic test_edge_settings();
      load_settings(32'hABCD_0000, 32'h0001_FFFF, 32'hFFFF_FFFF, 32'h0000_0100);
      send_pass(16'hFFFF, 32'd5000, 1'b0);
      send_pass(16'd1, mon_last_tick - 32'd1, 1'b0);
      load_settings(32'h0000_FFFF, 32'd0, 32'd16, 32'h0000_0100);
      send_pass(16'd5, 32'hFFFF_FFF8, 1'b0);
      send_pass(16'd5, 32'h0000_0007, 1'b0);
      send_pass(16'd5, 32'h0000_0008, 1'b0);
      send_pass(16'd5, 32'h0000_0009, 1'b1);
      send_pass(16'd5, 32'h0000_000A, 1'b0);
   endtask

   task automatic test_random_default();
      load_settings(lvsm_pkg::LOW_THRESHOLD_RESET, lvsm_pkg::WORKING_THRESHOLD_RESET,
                    lvsm_pkg::CHECK_INTERVAL_RESET, lvsm_pkg::CONFIRM_LIMIT_RESET);
      run_random(60, 8);
   endtask

   task automatic test_random_band();
      load_settings(32'd2800, 32'd3600, $urandom_range(50, 0), $urandom_range(8, 1));
      run_random(60, 10);
   endtask

   // Every nonzero sample is low and every pass re-checks: drive the count to its ceiling
   task automatic test_count_ceiling();
      load_settings(32'h0000_FFFF, 32'h0000_FFFF, 32'd0, 32'd255);
      run_random(270, 0);
   endtask

   task automatic test_random_settings();
      logic [31:0] low_mv, work_mv, interval, confirm;
      for (int unsigned k = 0; k < 4; k++) begin
         case ($urandom_range(2, 0))
            0: low_mv = 32'd0;
            1: low_mv = 32'h0000_FFFF;
            default: low_mv = $urandom_range(4000, 2000);
         endcase
         case ($urandom_range(2, 0))
            0: work_mv = 32'd0;
            1: work_mv = 32'h0000_FFFF;
            default: work_mv = $urandom_range(4500, 2500);
         endcase
         case ($urandom_range(2, 0))
            0: interval = 32'd0;
            1: interval = 32'hFFFF_FFFF;
            default: interval = $urandom_range(64, 1);
         endcase
         case ($urandom_range(3, 0))
            0: confirm = 32'd1;
            1: confirm = 32'd255;
            2: confirm = 32'h0000_0100;
            default: confirm = $urandom_range(6, 1);
         endcase
         load_settings(low_mv, work_mv, interval, confirm);
         run_random(15, 10);
      end
   endtask

   // Receiver: stall style changes every window, including windows that never stall
   int unsigned stall_style;
   int unsigned stall_window;
   int unsigned stall_phase;

   always @(posedge clock) begin
      if (stall_window == 0) begin
         stall_style  <= $urandom_range(3, 0);
         stall_window <= $urandom_range(80, 20);
         stall_phase  <= 0;
      end else begin
         stall_window <= stall_window - 1;
         stall_phase  <= stall_phase + 1;
      end
      case (stall_style)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= ($urandom_range(3, 0) != 0);
         2:       rsp_tready <= (stall_phase % 3 == 0);
         default: rsp_tready <= ($urandom_range(3, 0) == 0);
      endcase
   end

   // Compare each result beat with the oldest queued status
   always @(posedge clock) begin : check_results
      status_beat_type want;
      status_beat_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.mode             = rsp_tdata[2:0];
         got.shutdown_request = rsp_tdata[3];
         got.low_samples      = rsp_tdata[11:4];
         if (expected_status.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("[%0t] unexpected result beat: mode %0d req %0b count %0d", $realtime,
                        got.mode, got.shutdown_request, got.low_samples);
         end else begin
            want = expected_status.pop_front();
            results_checked++;
            if (got != want) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("[%0t] result %0d: expected mode %0d req %0b count %0d",
                           $realtime, results_checked, want.mode, want.shutdown_request,
                           want.low_samples);
                  $display("          got mode %0d req %0b count %0d",
                           got.mode, got.shutdown_request, got.low_samples);
               end
            end
         end
      end
   end

   // End the run when no beat moves on any channel for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("Watchdog: no beat moved for %0d cycles, %0d results still due",
                     WATCHDOG_LIMIT, expected_status.size());
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      cfg_low_mv          = lvsm_pkg::LOW_THRESHOLD_RESET;
      cfg_work_mv         = lvsm_pkg::WORKING_THRESHOLD_RESET;
      cfg_interval        = lvsm_pkg::CHECK_INTERVAL_RESET;
      cfg_confirm         = lvsm_pkg::CONFIRM_LIMIT_RESET;
      mon_mode            = lvsm_pkg::MODE_CODE_NORMAL;
      mon_last_tick       = 32'd0;
      mon_low_count       = 8'd0;
      burst_left          = 0;
      passes_sent         = 0;
      results_checked     = 0;
      mismatch_count      = 0;
      shutdowns_predicted = 0;
      settings_loaded     = 0;
      stall_cycles        = 0;
      stall_style         = 0;
      stall_window        = 0;
      stall_phase         = 0;
      peak_low_count      = 8'd0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_settings();
      test_working_band();
      test_edge_settings();
      test_random_default();
      test_random_band();
      test_count_ceiling();
      test_random_settings();

      // Drain, then give any stray beat time to show up
      wait_drained();
      repeat (10) @(posedge clock);

      $display("Checked %0d of %0d passes across %0d register settings (reset values too).",
               results_checked, passes_sent, settings_loaded);
      $display("Shutdown requests predicted: %0d, peak low sample count: %0d.",
               shutdowns_predicted, peak_low_count);
      if (mismatch_count == 0 && expected_status.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Mismatches: %0d, results still due: %0d", mismatch_count,
                  expected_status.size());
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== low_voltage_shutdown_monitor_top.f =====
rtl/lvsm_pkg.sv
rtl/lvsm_step.sv
rtl/low_voltage_shutdown_monitor_top.sv
tb/low_voltage_shutdown_monitor_top_test.sv
